FILE: hdl/tpt_pkg.sv
// Shared constants and types for the timer pool table.
`timescale 1ns / 1ps
package tpt_pkg;

   localparam int ENTRIES = 128;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int MODE_W  = 3;
   localparam int INDEX_W = 7;
   localparam int EXP_W   = 31;
   localparam int TICK_W  = 32;
   localparam int STAT_W  = 2;
   localparam int USE_W   = 8;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_REMAIN = 3'd6;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd7;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_BADARG = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

   // One timer record as held in the entry memory.
   typedef struct packed {
      logic [TICK_W-1:0] start_tick;
      logic [EXP_W-1:0]  expiry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: hdl/tpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/timer_pool_table_core.sv
// Timer pool: tick counter, allocation bits and entry memory with one update per operation.
// A result is registered in the execute state, which is entered on the accept of its request beat;
// that state is extended while an earlier result is still held on the result side.
// A request beat is taken only in the idle state, so each operation finishes before the next,
// set by the read-modify-write of the entry memory (read on accept, write-back in execute).
// Reset clears the tick counter, use count, used/running flags and expiry valid bits at once;
// an entry whose expiry was never written reads as zero, so no clearing pass is run.
`timescale 1ns / 1ps
module timer_pool_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [6:0] timer_index, [37:7] expiry_ms, [39:38] zero
   input  logic [tpt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] mode
   input  logic [tpt_pkg::MODE_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [8:2] granted_index, [9] fired, [40:10] time_left,
   // [48:41] entries_in_use, [55:49] zero
   output logic [tpt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import tpt_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                state_ff, state_in;
   logic [TICK_W-1:0]   now_ff, now_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ENTRIES-1:0]  used_ff, used_in;
   logic [ENTRIES-1:0]  run_ff, run_in;
   logic [ENTRIES-1:0]  expv_ff, expv_in;

   logic [MODE_W-1:0]   mode_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                bad_ff;
   logic [EXP_W-1:0]    exp_ff;
   logic [IDX_W-1:0]    free_ff;
   logic                full_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                done;
   logic [INDEX_W-1:0]  req_index;
   logic [EXP_W-1:0]    req_expiry;
   logic [IDX_W-1:0]    free_idx;
   logic                any_free;

   entry_type           rd_entry;
   entry_type           wr_entry;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;

   logic [EXP_W-1:0]    cur_exp;
   logic                cur_run;
   logic [TICK_W-1:0]   elapsed;
   logic                reached;

   logic [STAT_W-1:0]   status;
   logic [IDX_W-1:0]    granted;
   logic                fired;
   logic [EXP_W-1:0]    left;

   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_expiry = req_tdata[INDEX_W +: EXP_W];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign done       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // First unused entry, lowest index wins.
   always_comb begin
      free_idx = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (!used_ff[k]) begin
            free_idx = IDX_W'(k);
         end
      end
      any_free = ~&used_ff;
   end

   tpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (IDX_W'(req_index)),
      .rd_data (rd_entry)
   );

   // Read side of the operation.
   always_comb begin
      cur_exp = expv_ff[idx_ff] ? rd_entry.expiry : '0;
      cur_run = run_ff[idx_ff];
      elapsed = now_ff - rd_entry.start_tick;
      reached = (elapsed >= {1'b0, cur_exp});
   end

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      used_in      = used_ff;
      run_in       = run_ff;
      expv_in      = expv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      status       = ST_OK;
      granted      = '0;
      fired        = 1'b0;
      left         = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_entry     = rd_entry;
      wr_entry.expiry = cur_exp;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (done) begin
               state_in = S_IDLE;
               if (mode_ff == MODE_TICK) begin
                  now_in = now_ff + 1'b1;
               end else if (mode_ff == MODE_ALLOC) begin
                  if (exp_ff == '0) begin
                     status = ST_BADARG;
                  end else if (full_ff) begin
                     status = ST_FULL;
                  end else begin
                     granted                = free_ff;
                     used_in[free_ff]       = 1'b1;
                     run_in[free_ff]        = 1'b0;
                     expv_in[free_ff]       = 1'b1;
                     cnt_in                 = cnt_ff + 1'b1;
                     wr_en                  = 1'b1;
                     wr_addr                = free_ff;
                     wr_entry.expiry        = exp_ff;
                     wr_entry.start_tick    = '0;
                  end
               end else if (bad_ff) begin
                  status = ST_BADARG;
               end else begin
                  case (mode_ff)
                     MODE_START: begin
                        run_in[idx_ff]      = 1'b1;
                        expv_in[idx_ff]     = 1'b1;
                        wr_en               = 1'b1;
                        wr_entry.start_tick = now_ff;
                     end
                     MODE_STOP: begin
                        run_in[idx_ff]      = 1'b0;
                        expv_in[idx_ff]     = 1'b1;
                        wr_en               = 1'b1;
                        wr_entry.start_tick = '0;
                     end
                     MODE_SET: begin
                        expv_in[idx_ff]     = 1'b1;
                        wr_en               = 1'b1;
                        wr_entry.expiry     = exp_ff;
                     end
                     MODE_CHECK: begin
                        if (cur_run && reached) begin
                           fired               = 1'b1;
                           run_in[idx_ff]      = 1'b0;
                           expv_in[idx_ff]     = 1'b1;
                           wr_en               = 1'b1;
                           wr_entry.start_tick = '0;
                        end
                     end
                     MODE_REMAIN: begin
                        if (!cur_run) begin
                           left = cur_exp;
                        end else if (!reached) begin
                           // elapsed is below the 31-bit expiry here
                           left = cur_exp - elapsed[EXP_W-1:0];
                        end
                     end
                     default: begin
                        // remove: free the slot and zero the record
                        if (used_ff[idx_ff] && (cnt_ff != '0)) begin
                           cnt_in = cnt_ff - 1'b1;
                        end
                        used_in[idx_ff]     = 1'b0;
                        run_in[idx_ff]      = 1'b0;
                        expv_in[idx_ff]     = 1'b1;
                        wr_en               = 1'b1;
                        wr_entry.expiry     = '0;
                        wr_entry.start_tick = '0;
                     end
                  endcase
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({USE_W'(cnt_in), left, fired,
                                          INDEX_W'(granted), status});
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         cnt_ff       <= '0;
         used_ff      <= '0;
         run_ff       <= '0;
         expv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         run_ff       <= run_in;
         expv_ff      <= expv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the operation on accept; the free slot is sampled with it.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         mode_ff <= req_tuser;
         idx_ff  <= IDX_W'(req_index);
         bad_ff  <= (32'(req_index) >= 32'(ENTRIES));
         exp_ff  <= req_expiry;
         free_ff <= free_idx;
         full_ff <= !any_free;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(cnt_ff))
      else $error("use count differs from number of used entries");

   a_accept_execs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted beat not executed");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised outside execute state");

endmodule
